// File: rtl/catmull_rom_spline_eval_defines.svh
// ----------------------------------------------------------------------------
// Catmull-Rom spline evaluator assertion macros
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef CATMULL_ROM_SPLINE_EVAL_DEFINES_SVH
`define CATMULL_ROM_SPLINE_EVAL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRSE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("crse assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CRSE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("crse assertion failed");

`endif

// File: rtl/crse_pkg.sv
// ----------------------------------------------------------------------------
// Catmull-Rom spline evaluator package
// Widths, constants and pipeline payload types shared by all modules.
// ----------------------------------------------------------------------------
`default_nettype none

package crse_pkg;

    localparam int COORD_W     = 32;
    localparam int T_FRAC      = 16;
    localparam int T_W         = T_FRAC + 1;
    localparam int ACC_W       = COORD_W + 8;
    localparam int PROD_W      = ACC_W + T_W;
    localparam int IN_TDATA_W  = ((4 * COORD_W + T_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = COORD_W;
    localparam int OUT_TUSER_W = 1;

    localparam logic [T_W-1:0]    T_ONE    = {1'b1, {T_FRAC{1'b0}}};
    localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (T_FRAC - 1);

    typedef struct packed {
        logic signed [COORD_W-1:0] point_before;
        logic signed [COORD_W-1:0] point_start;
        logic signed [COORD_W-1:0] point_end;
        logic signed [COORD_W-1:0] point_after;
        logic        [T_W-1:0]     param_t;
    } t_point_set;

    typedef struct packed {
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] add0;
        logic signed [ACC_W-1:0] add1;
        logic signed [ACC_W-1:0] add2;
        logic        [T_W-1:0]   t;
    } t_work;

endpackage

`default_nettype wire

// File: rtl/crse_coef.sv
// ----------------------------------------------------------------------------
// Catmull-Rom coefficient stage
// Three pipeline stages forming the doubled cubic coefficients from the
// control values, with the parameter clamped to one.
// ----------------------------------------------------------------------------
`default_nettype none

module crse_coef (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_tangent_half,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire crse_pkg::t_point_set i_pts,
    output logic                     o_valid,
    input  wire                      i_ready,
    output crse_pkg::t_work          o_work
);
    import crse_pkg::*;

    localparam int NSTG = 3;
    localparam int DW   = COORD_W + 1;

    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   w_adv;

    logic signed [DW-1:0]      r_s1, r_s2, r_dd;
    logic signed [COORD_W-1:0] r_p2;
    logic [T_W-1:0]            r_t0, r_t1;
    logic                      r_half0, r_half1;

    logic signed [DW:0]   r_ss, r_c;
    logic signed [DW+1:0] r_ts, r_d4;
    logic signed [DW+2:0] r_d6;
    logic signed [DW-1:0] r_d;

    t_work r_work;

    logic [T_W-1:0]       n_t0;
    logic signed [DW-1:0] n_s1, n_s2, n_dd;
    logic signed [DW:0]   n_ss, n_c;
    logic signed [DW+1:0] n_ts, n_d4;
    logic signed [DW+2:0] n_d6;
    logic signed [DW-1:0] n_d;
    t_work                n_work;

    always_comb begin
        w_adv[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_adv[k] = ~r_vld[k] | w_adv[k+1];
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_work  = r_work;

    always_comb begin
        n_t0 = (i_pts.param_t > T_ONE) ? T_ONE : i_pts.param_t;
        n_s1 = DW'(i_pts.point_end) - DW'(i_pts.point_before);
        n_s2 = DW'(i_pts.point_after) - DW'(i_pts.point_start);
        n_dd = DW'(i_pts.point_start) - DW'(i_pts.point_end);
    end

    always_comb begin
        n_ss = (DW+1)'(r_s1) + (DW+1)'(r_s2);
        n_ts = ((DW+2)'(r_s1) <<< 1) + (DW+2)'(r_s2);
        n_d4 = (DW+2)'(r_dd) <<< 2;
        n_d6 = ((DW+3)'(r_dd) <<< 2) + ((DW+3)'(r_dd) <<< 1);
        n_c  = r_half0 ? (DW+1)'(r_s1) : ((DW+1)'(r_s1) <<< 1);
        n_d  = DW'(r_p2) <<< 1;
    end

    always_comb begin
        n_work.acc  = ACC_W'(r_d4) + (r_half1 ? ACC_W'(r_ss) : (ACC_W'(r_ss) <<< 1));
        n_work.add0 = -ACC_W'(r_d6) - (r_half1 ? ACC_W'(r_ts) : (ACC_W'(r_ts) <<< 1));
        n_work.add1 = ACC_W'(r_c);
        n_work.add2 = ACC_W'(r_d);
        n_work.t    = r_t1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) r_vld[0] <= i_valid;
            if (w_adv[1]) r_vld[1] <= r_vld[0];
            if (w_adv[2]) r_vld[2] <= r_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_s1    <= n_s1;
            r_s2    <= n_s2;
            r_dd    <= n_dd;
            r_p2    <= i_pts.point_start;
            r_t0    <= n_t0;
            r_half0 <= i_tangent_half;
        end
        if (w_adv[1]) begin
            r_ss    <= n_ss;
            r_ts    <= n_ts;
            r_d4    <= n_d4;
            r_d6    <= n_d6;
            r_c     <= n_c;
            r_d     <= n_d;
            r_t1    <= r_t0;
            r_half1 <= r_half0;
        end
        if (w_adv[2]) begin
            r_work <= n_work;
        end
    end

endmodule

`default_nettype wire

// File: rtl/crse_horner.sv
// ----------------------------------------------------------------------------
// Catmull-Rom Horner step
// One multiply-round-add step of the cubic, in four pipeline stages:
// magnitude, multiply, round, signed accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module crse_horner (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire crse_pkg::t_work i_work,
    output logic                 o_valid,
    input  wire                  i_ready,
    output crse_pkg::t_work      o_work
);
    import crse_pkg::*;

    localparam int NSTG = 4;

    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   w_adv;

    logic              r_sign0, r_sign1, r_sign2;
    logic [ACC_W-1:0]  r_mag;
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_q;
    t_work             r_w0, r_w1, r_w2, r_w3;

    logic [ACC_W-1:0]  n_mag;
    logic [PROD_W-1:0] n_prod;
    logic [PROD_W-1:0] n_rsum;
    t_work             n_w3;

    always_comb begin
        w_adv[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_adv[k] = ~r_vld[k] | w_adv[k+1];
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_work  = r_w3;

    always_comb begin
        n_mag  = i_work.acc[ACC_W-1] ? ACC_W'(-i_work.acc) : ACC_W'(i_work.acc);
        n_prod = r_mag * r_w0.t;
        n_rsum = r_prod + RND_HALF;
    end

    always_comb begin
        n_w3      = r_w2;
        n_w3.acc  = r_sign2 ? (r_w2.add0 - $signed(r_q)) : (r_w2.add0 + $signed(r_q));
        n_w3.add0 = r_w2.add1;
        n_w3.add1 = r_w2.add2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) r_vld[0] <= i_valid;
            if (w_adv[1]) r_vld[1] <= r_vld[0];
            if (w_adv[2]) r_vld[2] <= r_vld[1];
            if (w_adv[3]) r_vld[3] <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_sign0 <= i_work.acc[ACC_W-1];
            r_mag   <= n_mag;
            r_w0    <= i_work;
        end
        if (w_adv[1]) begin
            r_sign1 <= r_sign0;
            r_prod  <= n_prod;
            r_w1    <= r_w0;
        end
        if (w_adv[2]) begin
            r_sign2 <= r_sign1;
            r_q     <= n_rsum[T_FRAC +: ACC_W];
            r_w2    <= r_w1;
        end
        if (w_adv[3]) begin
            r_w3 <= n_w3;
        end
    end

endmodule

`default_nettype wire

// File: rtl/crse_out.sv
// ----------------------------------------------------------------------------
// Catmull-Rom output stage
// Halves the doubled result with rounding away from zero, saturates it to
// the coordinate range and holds it in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crse_out (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire crse_pkg::t_work         i_work,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [crse_pkg::COORD_W-1:0] o_value,
    output logic                         o_sat
);
    import crse_pkg::*;

    localparam int NSTG = 2;
    localparam int YW   = ACC_W - 1;

    localparam logic signed [YW-1:0]      Y_MAX = YW'({1'b0, {(COORD_W-1){1'b1}}});
    localparam logic signed [YW-1:0]      Y_MIN = -Y_MAX - 1;
    localparam logic        [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic        [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   w_adv;

    logic signed [YW-1:0]    r_y;
    logic [COORD_W-1:0]      r_value;
    logic                    r_sat;

    logic signed [ACC_W-1:0] n_inc;
    logic [COORD_W-1:0]      n_value;
    logic                    n_sat;

    always_comb begin
        w_adv[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_adv[k] = ~r_vld[k] | w_adv[k+1];
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_value = r_value;
    assign o_sat   = r_sat;

    always_comb begin
        n_inc = i_work.acc + $signed({{(ACC_W-1){1'b0}}, ~i_work.acc[ACC_W-1]});
        if (r_y > Y_MAX) begin
            n_value = C_MAX;
            n_sat   = 1'b1;
        end else if (r_y < Y_MIN) begin
            n_value = C_MIN;
            n_sat   = 1'b1;
        end else begin
            n_value = r_y[COORD_W-1:0];
            n_sat   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) r_vld[0] <= i_valid;
            if (w_adv[1]) r_vld[1] <= r_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_y <= n_inc[ACC_W-1:1];
        end
        if (w_adv[1]) begin
            r_value <= n_value;
            r_sat   <= n_sat;
        end
    end

endmodule

`default_nettype wire

// File: rtl/catmull_rom_spline_eval.sv
// ----------------------------------------------------------------------------
// Catmull-Rom spline evaluator
// Evaluates one coordinate axis of a cubic Catmull-Rom segment per
// transaction, with a saturated Q16.16 result.
// ----------------------------------------------------------------------------
// The block accepts one transaction per clock cycle when the output side
// does not stall. Three stages build the coefficients, each of the three
// Horner steps takes four stages around its own 40 by 17 bit multiplier,
// and two stages round, saturate and register the result. Empty stages
// fill up while the output is stalled, so input transactions keep being
// taken until the pipeline is full. The tangent_half register is written
// through i_cfg_wen and i_cfg_wdata and should only change while no
// transaction is in flight.
`default_nettype none

module catmull_rom_spline_eval (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_wen,
    input  wire                              i_cfg_wdata,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // point_before, point_start, point_end, point_after, param_t, zero pad.
    input  wire [crse_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // curve_value.
    output logic [crse_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // saturated.
    output logic [crse_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import crse_pkg::*;

    logic       r_tangent_half;
    t_point_set w_pts;
    logic [3:0] w_vld;
    logic [3:0] w_rdy;
    t_work      w_work [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tangent_half <= 1'b1;
        end else if (i_cfg_wen) begin
            r_tangent_half <= i_cfg_wdata;
        end
    end

    assign w_pts.point_before = s_axis_tdata[0*COORD_W +: COORD_W];
    assign w_pts.point_start  = s_axis_tdata[1*COORD_W +: COORD_W];
    assign w_pts.point_end    = s_axis_tdata[2*COORD_W +: COORD_W];
    assign w_pts.point_after  = s_axis_tdata[3*COORD_W +: COORD_W];
    assign w_pts.param_t      = s_axis_tdata[4*COORD_W +: T_W];

    crse_coef u_coef (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tangent_half (r_tangent_half),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_pts          (w_pts),
        .o_valid        (w_vld[0]),
        .i_ready        (w_rdy[0]),
        .o_work         (w_work[0])
    );

    for (genvar g = 0; g < 3; g++) begin : g_horner
        crse_horner u_horner (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[g]),
            .o_ready (w_rdy[g]),
            .i_work  (w_work[g]),
            .o_valid (w_vld[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_work  (w_work[g+1])
        );
    end

    crse_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_vld[3]),
        .o_ready (w_rdy[3]),
        .i_work  (w_work[3]),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_value (m_axis_tdata),
        .o_sat   (m_axis_tuser[0])
    );

endmodule

`default_nettype wire

// File: rtl/crse_checker.sv
// ----------------------------------------------------------------------------
// Catmull-Rom spline evaluator port checker
// Port-level properties of the evaluator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none
`include "catmull_rom_spline_eval_defines.svh"

module crse_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              s_axis_tready,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [crse_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input wire [crse_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
    import crse_pkg::*;

    localparam logic [OUT_TDATA_W-1:0] OUT_MAX = {1'b0, {(OUT_TDATA_W-1){1'b1}}};
    localparam logic [OUT_TDATA_W-1:0] OUT_MIN = {1'b1, {(OUT_TDATA_W-1){1'b0}}};

    // A stalled result stays on the bus unchanged.
    `CRSE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // A saturated result sits at one end of the coordinate range.
    `CRSE_ASSERT_IMP(a_sat_clamp, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata == OUT_MAX) || (m_axis_tdata == OUT_MIN))

    // The input only backs up when a result is waiting on a stalled output.
    `CRSE_ASSERT_IMP(a_in_backpressure, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

bind catmull_rom_spline_eval crse_checker u_crse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
